// ===== rtl/ple_pkg.sv =====
`default_nettype none

package ple_pkg;

   // operation codes carried in the request
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_READ   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_BADPOS = 2'd1,
      ST_FULL   = 2'd2,
      ST_UNUSED = 2'd3
   } status_type;

   // field widths fixed by the stream format
   localparam int unsigned OP_W     = 2;
   localparam int unsigned POS_W    = 5;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned COUNT_W  = 5;
   localparam int unsigned REQ_W    = 40;
   localparam int unsigned RSP_W    = 40;

   // shift command broadcast to every cell
   typedef struct packed {
      logic ins;   // shift up from the position, store the value there
      logic del;   // shift down from the position
   } cell_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/ple_cell.sv =====
`default_nettype none

module ple_cell import ple_pkg::*; #(
   parameter int unsigned INDEX = 0,
   parameter int unsigned PW    = 6
) (
   input  wire logic               clock,
   input  wire cell_cmd_type       cmd,
   input  wire logic [PW-1:0]      slot,        // 0-based target position
   input  wire logic [VALUE_W-1:0] value,
   input  wire logic [VALUE_W-1:0] lower_entry, // neighbor below
   input  wire logic [VALUE_W-1:0] upper_entry, // neighbor above
   output logic      [VALUE_W-1:0] entry,
   output logic      [VALUE_W-1:0] read_term    // entry when addressed, else zero
);

   localparam logic [PW-1:0] MY_IDX = PW'(INDEX);

   logic [VALUE_W-1:0] entry_ff;
   logic [VALUE_W-1:0] entry_in;
   logic               at_slot;
   logic               above_slot;

   assign at_slot    = (slot == MY_IDX);
   assign above_slot = (MY_IDX > slot);

   // select next content: hold, new value, or a neighbor's entry
   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins) begin
         if (at_slot) begin
            entry_in = value;
         end else if (above_slot) begin
            entry_in = lower_entry;
         end
      end else if (cmd.del) begin
         if (at_slot || above_slot) begin
            entry_in = upper_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry     = entry_ff;
   assign read_term = at_slot ? entry_ff : '0;

endmodule

`default_nettype wire

// ===== rtl/positional_list_engine_core.sv =====
`default_nettype none

// Positional list engine: a bounded ordered list of signed 32-bit values held in
// a row of DEPTH cells, one entry per cell. A request carries op (0 insert,
// 1 delete, 2 read), a 1-based position and a value; every request gives one
// response with status (0 done, 1 invalid position, 2 list full), the entry
// count after the operation and the value read (zero unless a read succeeds).
// All cells compare their index with the position and shift toward their
// neighbor in the same cycle, so one request is accepted per clock cycle and
// its response is ready in the response register on the next cycle. The
// response register is the only buffer: a stalled response holds off the
// next request only while it is not taken. Rejected requests leave the list
// unchanged. No clearing pass is needed after reset.
module positional_list_engine_core import ple_pkg::*; #(
   parameter int unsigned DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // request: [1:0] op, [6:2] position, [38:7] value, [39] zero
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,
   // response: [1:0] status, [6:2] entry_count, [38:7] read_value, [39] zero
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic      [RSP_W-1:0] rsp_tdata
);

   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned PW = ((CW > POS_W) ? CW : POS_W) + 1;
   localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

   // request fields
   op_type             req_op;
   logic [POS_W-1:0]   req_position;
   logic [VALUE_W-1:0] req_value;

   assign req_op       = op_type'(req_tdata[OP_W-1:0]);
   assign req_position = req_tdata[OP_W+POS_W-1:OP_W];
   assign req_value    = req_tdata[OP_W+POS_W+VALUE_W-1:OP_W+POS_W];

   logic accept;
   assign accept = req_tvalid && req_tready;

   // list length and response register
   logic [CW-1:0]       count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          status_ff, status_in;
   logic [COUNT_W-1:0]  rcount_ff, rcount_in;
   logic [VALUE_W-1:0]  rdata_ff, rdata_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;

   // range checks
   logic [PW-1:0] pos_p, cnt_p, slot;
   logic          pos_nonzero, ins_ok, in_list, full;

   assign pos_p       = PW'(req_position);
   assign cnt_p       = PW'(count_ff);
   assign slot        = pos_p - PW'(1);
   assign pos_nonzero = (req_position != '0);
   assign ins_ok      = pos_nonzero && (pos_p <= cnt_p + PW'(1));
   assign in_list     = pos_nonzero && (pos_p <= cnt_p);
   assign full        = (cnt_p >= DEPTH_P);

   cell_cmd_type cmd;

   // decode the request
   always_comb begin
      cmd       = '0;
      status_in = ST_BADPOS;
      count_in  = count_ff;
      unique case (req_op)
         OP_INSERT: begin
            if (ins_ok) begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  status_in = ST_DONE;
                  cmd.ins   = accept;
                  count_in  = count_ff + CW'(1);
               end
            end
         end
         OP_DELETE: begin
            if (in_list) begin
               status_in = ST_DONE;
               cmd.del   = accept;
               count_in  = count_ff - CW'(1);
            end
         end
         OP_READ: begin
            if (in_list) begin
               status_in = ST_DONE;
            end
         end
         default: begin
            status_in = ST_BADPOS;
         end
      endcase
   end

   // row of cells
   logic [VALUE_W-1:0] entries    [DEPTH];
   logic [VALUE_W-1:0] read_terms [DEPTH];

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [VALUE_W-1:0] lower, upper;
      if (g == 0) begin : g_lo
         assign lower = '0;
      end else begin : g_lo
         assign lower = entries[g-1];
      end
      if (g == DEPTH - 1) begin : g_hi
         assign upper = '0;
      end else begin : g_hi
         assign upper = entries[g+1];
      end
      ple_cell #(
         .INDEX (g),
         .PW    (PW)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .slot        (slot),
         .value       (req_value),
         .lower_entry (lower),
         .upper_entry (upper),
         .entry       (entries[g]),
         .read_term   (read_terms[g])
      );
   end

   // gather the addressed entry
   logic [VALUE_W-1:0] read_any;
   always_comb begin
      read_any = '0;
      for (int i = 0; i < DEPTH; i++) begin
         read_any = read_any | read_terms[i];
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);
   assign rcount_in    = COUNT_W'(count_in);
   assign rdata_in     = ((req_op == OP_READ) && in_list) ? read_any : '0;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         rcount_ff <= rcount_in;
         rdata_ff  <= rdata_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rdata_ff, rcount_ff, status_ff};

endmodule

`default_nettype wire
